/* design/pee_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
`default_nettype none

package pee_pkg;

    // ASCII codes the decoder recognizes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam int unsigned VALUE_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LHS,
        S_EXEC,
        S_ARITH,
        S_FINAL,
        S_EMIT
    } state_t;

    // Sticky error flags of one expression
    typedef struct packed {
        logic bad_char;
        logic div_by_zero;
        logic overflow;
        logic underflow;
    } err_t;

    // Request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    // Status from the multiply/divide unit
    typedef struct packed {
        logic done;
        logic div_zero;
    } md_rsp_t;

endpackage

`default_nettype wire

/* design/pee_muldiv.sv */
// Iterative multiply and signed truncating divide, one bit per cycle.
`default_nettype none

module pee_muldiv #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pee_pkg::md_req_t      req,
    input  wire logic [DATA_WIDTH-1:0] lhs,
    input  wire logic [DATA_WIDTH-1:0] rhs,
    output pee_pkg::md_rsp_t           rsp,
    output logic [DATA_WIDTH-1:0]      result
);

    localparam int unsigned SW = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  dz_reg, dz_next;
    logic                  is_div_reg, is_div_next;
    logic                  neg_reg, neg_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;   // product / remainder
    logic [DATA_WIDTH-1:0] a_reg, a_next;       // multiplicand / quotient
    logic [DATA_WIDTH-1:0] b_reg, b_next;       // multiplier / divisor

    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dz_reg     <= dz_next;
        is_div_reg <= is_div_next;
        neg_reg    <= neg_next;
        step_reg   <= step_next;
        acc_reg    <= acc_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        dz_next     = dz_reg;
        is_div_next = is_div_reg;
        neg_next    = neg_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        rem_sh      = {acc_reg, a_reg[DATA_WIDTH-1]};
        diff        = rem_sh - {1'b0, b_reg};

        if (req.start)
        begin
            is_div_next = req.is_div;
            dz_next     = 1'b0;
            neg_next    = 1'b0;
            acc_next    = '0;
            step_next   = SW'(DATA_WIDTH);
            if (req.is_div)
            begin
                if (rhs == '0)
                begin
                    // zero divisor: quotient forced to zero, finish at once
                    dz_next   = 1'b1;
                    a_next    = '0;
                    done_next = 1'b1;
                end
                else
                begin
                    a_next    = lhs[DATA_WIDTH-1] ? -lhs : lhs;
                    b_next    = rhs[DATA_WIDTH-1] ? -rhs : rhs;
                    neg_next  = lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
                    busy_next = 1'b1;
                end
            end
            else
            begin
                a_next    = lhs;
                b_next    = rhs;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                // restoring step: shift in next dividend bit, try subtract
                if (!diff[DATA_WIDTH])
                begin
                    acc_next = diff[DATA_WIDTH-1:0];
                end
                else
                begin
                    acc_next = rem_sh[DATA_WIDTH-1:0];
                end
                a_next = {a_reg[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[DATA_WIDTH-2:0], 1'b0};
                b_next = {1'b0, b_reg[DATA_WIDTH-1:1]};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign result       = is_div_reg ? (neg_reg ? -a_reg : a_reg) : acc_reg;
    assign rsp.done     = done_reg;
    assign rsp.div_zero = dz_reg;

endmodule

`default_nettype wire

/* design/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator: decoder, operand stack and sequencer.
//
// Takes one ASCII character per input transfer and evaluates a postfix
// expression on an operand stack of STACK_DEPTH entries held in a simple
// dual-port synchronous memory (one read, one write per cycle, registered
// read).
// A space, a digit or an unknown character is handled in S_IDLE. An operator
// passes through S_LHS and S_EXEC, since the two operands come out of the
// memory one read at a time; * and / then run on a shared bit-serial unit in
// S_ARITH until it is done. A character flagged as last then passes through
// S_FINAL for the final pop and S_EMIT, which waits for the output register
// to free up. Popping an empty stack yields -1 and sets underflow, a push onto
// a full stack is dropped and sets overflow, a zero divisor yields 0 and sets
// div_by_zero, and anything other than a digit, space or operator sets
// bad_char and is otherwise ignored. The result value is sign-extended (or
// truncated) from DATA_WIDTH to 32 bits. Once the result is loaded into the
// output register the stack and flags are cleared; the next expression may
// start while the result still waits to be taken.
`default_nettype none

module postfix_expression_evaluator #(
    parameter int unsigned STACK_DEPTH = 64,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_expr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] value,
    output logic             underflow,
    output logic             overflow,
    output logic             div_by_zero,
    output logic             bad_char
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    // Control state
    pee_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    pee_pkg::err_t   err_reg, err_next;
    logic            out_valid_reg, out_valid_next;

    // Per-item working registers
    pee_pkg::op_t          op_reg, op_next;
    logic                  last_reg, last_next;
    logic                  pop_ok_reg, pop_ok_next;
    logic [DATA_WIDTH-1:0] rhs_reg, rhs_next;

    // Output payload
    logic signed [31:0]    value_reg, value_next;
    pee_pkg::err_t         oflags_reg, oflags_next;

    // Operand stack memory
    logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  mem_we;

    logic                  push_en;
    logic [DATA_WIDTH-1:0] push_data;
    logic [DATA_WIDTH-1:0] popped;
    logic signed [DATA_WIDTH-1:0] fin_val;
    logic                  in_xfer;

    pee_pkg::md_req_t      md_req;
    pee_pkg::md_rsp_t      md_rsp;
    logic [DATA_WIDTH-1:0] md_result;

    pee_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .lhs    (popped),
        .rhs    (rhs_reg),
        .rsp    (md_rsp),
        .result (md_result)
    );

    // Memory: every cycle read the entry just below the current count
    assign rd_addr = AW'(count_reg - 1'b1);
    assign wr_addr = AW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= push_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // A failed pop reads as -1
    assign popped  = pop_ok_reg ? rd_data_reg : '1;
    assign fin_val = popped;

    assign in_ready = (state_reg == pee_pkg::S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pee_pkg::S_IDLE;
            count_reg     <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        last_reg   <= last_next;
        pop_ok_reg <= pop_ok_next;
        rhs_reg    <= rhs_next;
        value_reg  <= value_next;
        oflags_reg <= oflags_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op_next        = op_reg;
        last_next      = last_reg;
        pop_ok_next    = pop_ok_reg;
        rhs_next       = rhs_reg;
        value_next     = value_reg;
        oflags_next    = oflags_reg;
        push_en        = 1'b0;
        push_data      = '0;
        mem_we         = 1'b0;
        md_req         = '0;

        unique case (state_reg)
            pee_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    last_next  = end_of_expr;
                    state_next = end_of_expr ? pee_pkg::S_FINAL : pee_pkg::S_IDLE;
                    unique case (char_code) inside
                        pee_pkg::CH_SPACE:
                        begin
                        end
                        [pee_pkg::CH_ZERO:pee_pkg::CH_NINE]:
                        begin
                            push_en   = 1'b1;
                            push_data = DATA_WIDTH'(char_code - pee_pkg::CH_ZERO);
                        end
                        pee_pkg::CH_PLUS, pee_pkg::CH_MINUS,
                        pee_pkg::CH_STAR, pee_pkg::CH_SLASH:
                        begin
                            unique case (char_code)
                                pee_pkg::CH_PLUS:  op_next = pee_pkg::OP_ADD;
                                pee_pkg::CH_MINUS: op_next = pee_pkg::OP_SUB;
                                pee_pkg::CH_STAR:  op_next = pee_pkg::OP_MUL;
                                default:           op_next = pee_pkg::OP_DIV;
                            endcase
                            // pop the right operand; its data lands next cycle
                            pop_ok_next = (count_reg != '0);
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                err_next.underflow = 1'b1;
                            end
                            state_next = pee_pkg::S_LHS;
                        end
                        default:
                        begin
                            err_next.bad_char = 1'b1;
                        end
                    endcase
                end
            end

            pee_pkg::S_LHS:
            begin
                // hold the right operand, pop the left one
                rhs_next    = popped;
                pop_ok_next = (count_reg != '0);
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    err_next.underflow = 1'b1;
                end
                state_next = pee_pkg::S_EXEC;
            end

            pee_pkg::S_EXEC:
            begin
                case (op_reg)
                    pee_pkg::OP_ADD:
                    begin
                        push_en    = 1'b1;
                        push_data  = popped + rhs_reg;
                        state_next = last_reg ? pee_pkg::S_FINAL : pee_pkg::S_IDLE;
                    end
                    pee_pkg::OP_SUB:
                    begin
                        push_en    = 1'b1;
                        push_data  = popped - rhs_reg;
                        state_next = last_reg ? pee_pkg::S_FINAL : pee_pkg::S_IDLE;
                    end
                    default:
                    begin
                        md_req.start  = 1'b1;
                        md_req.is_div = (op_reg == pee_pkg::OP_DIV);
                        state_next    = pee_pkg::S_ARITH;
                    end
                endcase
            end

            pee_pkg::S_ARITH:
            begin
                if (md_rsp.done)
                begin
                    push_en    = 1'b1;
                    push_data  = md_result;
                    err_next.div_by_zero = err_reg.div_by_zero || md_rsp.div_zero;
                    state_next = last_reg ? pee_pkg::S_FINAL : pee_pkg::S_IDLE;
                end
            end

            pee_pkg::S_FINAL:
            begin
                // pop the result; data lands next cycle
                pop_ok_next = (count_reg != '0);
                if (count_reg == '0)
                begin
                    err_next.underflow = 1'b1;
                end
                state_next = pee_pkg::S_EMIT;
            end

            pee_pkg::S_EMIT:
            begin
                // load the output register once it is free, then clear state
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_next     = 32'(fin_val);
                    oflags_next    = err_reg;
                    count_next     = '0;
                    err_next       = '0;
                    state_next     = pee_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pee_pkg::S_IDLE;
            end
        endcase

        // Push: write at the current count, or drop on a full stack
        if (push_en)
        begin
            if (count_reg < CW'(STACK_DEPTH))
            begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                err_next.overflow = 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign underflow   = oflags_reg.underflow;
    assign overflow    = oflags_reg.overflow;
    assign div_by_zero = oflags_reg.div_by_zero;
    assign bad_char    = oflags_reg.bad_char;

endmodule

`default_nettype wire

/* design/pee_assert.sv */
// Port-level checks for the postfix expression evaluator, bound to the top level.
`default_nettype none

module pee_assert (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  char_code,
    input wire logic        end_of_expr,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] value
);

    // A waiting result holds its value until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("result changed while stalled");

    // The last character always leads to the final pop, so input stalls
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_expr |=> !in_ready)
        else $error("input taken right after last character");

    // An operator needs operand reads, so input stalls
    a_op_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (char_code == pee_pkg::CH_PLUS ||
        char_code == pee_pkg::CH_MINUS || char_code == pee_pkg::CH_STAR ||
        char_code == pee_pkg::CH_SLASH) |=> !in_ready)
        else $error("input taken right after operator");

    // A space that is not last does not stall input
    a_space_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !end_of_expr && char_code == pee_pkg::CH_SPACE
        |=> in_ready)
        else $error("space stalled input");

endmodule

bind postfix_expression_evaluator pee_assert u_pee_assert (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .end_of_expr (end_of_expr),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value)
);

`default_nettype wire

/* tb/sv/rpn_result_checker.sv */
// Result checker for the postfix expression evaluator: stack predictor and result compare.

module rpn_result_checker
    import pee_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               end_of_expr,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] value,
    input  logic               underflow,
    input  logic               overflow,
    input  logic               div_by_zero,
    input  logic               bad_char,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [31:0] value;
        err_t        flags;
    } expr_result_t;

    logic [31:0]  operands [STACK_DEPTH];
    int unsigned  depth;
    err_t         sticky;
    expr_result_t expected_results [$];

    // Empty stack reads back as all ones and marks underflow.
    function automatic logic [31:0] pop_operand();
        if (depth == 0) begin
            sticky.underflow = 1'b1;
            return '1;
        end
        depth--;
        return operands[depth];
    endfunction

    // Drop the value when the stack is full.
    task automatic push_operand(input logic [31:0] v);
        if (depth >= STACK_DEPTH) begin
            sticky.overflow = 1'b1;
        end else begin
            operands[depth] = v;
            depth++;
        end
    endtask

    task automatic evaluate_char(input logic [7:0] c, input logic last);
        logic [31:0]  rhs;
        logic [31:0]  lhs;
        logic [31:0]  res;
        longint       quot;
        op_t          op;
        expr_result_t r;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            push_operand(32'(c - CH_ZERO));
        end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
            case (c)
                CH_PLUS:  op = OP_ADD;
                CH_MINUS: op = OP_SUB;
                CH_STAR:  op = OP_MUL;
                default:  op = OP_DIV;
            endcase
            rhs = pop_operand();
            lhs = pop_operand();
            case (op)
                OP_ADD: res = lhs + rhs;
                OP_SUB: res = lhs - rhs;
                OP_MUL: res = lhs * rhs;
                default:
                begin
                    if (rhs == '0) begin
                        sticky.div_by_zero = 1'b1;
                        res = '0;
                    end else begin
                        // 64-bit quotient keeps most-negative / -1 from trapping
                        quot = longint'(signed'(lhs)) / longint'(signed'(rhs));
                        res  = quot[31:0];
                    end
                end
            endcase
            push_operand(res);
        end else if (c != CH_SPACE) begin
            sticky.bad_char = 1'b1;
        end
        if (last) begin
            r.value = pop_operand();
            r.flags = sticky;
            expected_results.push_back(r);
            depth  = 0;
            sticky = '0;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        expr_result_t want;
        if (!rst_n) begin
            depth      = 0;
            sticky     = '0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            // Retire the result first: it can never stem from a char taken at this edge.
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value %0h",
                             $time, value);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("value", want.value, value);
                    check_field("underflow", 32'(want.flags.underflow), 32'(underflow));
                    check_field("overflow", 32'(want.flags.overflow), 32'(overflow));
                    check_field("div_by_zero", 32'(want.flags.div_by_zero), 32'(div_by_zero));
                    check_field("bad_char", 32'(want.flags.bad_char), 32'(bad_char));
                end
            end
            if (in_valid && in_ready)
                evaluate_char(char_code, end_of_expr);
        end
        pending = expected_results.size();
    end

endmodule

/* tb/sv/tb_postfix_expression_evaluator.sv */
// Testbench top for the postfix expression evaluator: stimulus, flow control and verdict.

module tb_postfix_expression_evaluator;

    import pee_pkg::*;

    // Stop issuing new expressions once this many chars went through.
    localparam int unsigned ITEM_TARGET  = 1650;
    // Past this point both sides run without idling.
    localparam int unsigned QUIET_AFTER  = 1450;
    // Cycles without any transfer before the run is declared hung. The slowest
    // char is a divide plus final pop and output stalls, so this leaves a wide
    // margin.
    localparam int unsigned HANG_LIMIT   = 3000;
    // Settle time after the last expected result, above one full divide.
    localparam int unsigned DRAIN_CYCLES = 60;

    // Field extremes that are not valid characters.
    localparam logic [7:0] CH_LOWEST  = 8'h00;
    localparam logic [7:0] CH_HIGHEST = 8'hFF;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         char_code;
    logic               end_of_expr;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] value;
    logic               underflow;
    logic               overflow;
    logic               div_by_zero;
    logic               bad_char;

    int                 fail_count;
    int                 pending;
    int unsigned        sent;
    int unsigned        hang_count;
    int unsigned        stall_left;
    logic               tx_gaps;
    logic               rx_stalls;

    // Characters of the expression being built; the last one carries end_of_expr.
    logic [7:0]         line_buf [$];

    postfix_expression_evaluator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .end_of_expr (end_of_expr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .underflow   (underflow),
        .overflow    (overflow),
        .div_by_zero (div_by_zero),
        .bad_char    (bad_char)
    );

    // Watch both channels, predict every expression result and compare.
    rpn_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .end_of_expr (end_of_expr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .underflow   (underflow),
        .overflow    (overflow),
        .div_by_zero (div_by_zero),
        .bad_char    (bad_char),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side: stall in random bursts while stalls are enabled,
    // otherwise hold ready high.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (!rx_stalls) begin
            out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Hang detection: count cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            hang_count <= 0;
        end else if (hang_count >= HANG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            hang_count <= hang_count + 1;
        end
    end

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_operator();
        op_t op;
        op = op_t'($urandom_range(0, 3));
        case (op)
            OP_ADD:  return CH_PLUS;
            OP_SUB:  return CH_MINUS;
            OP_MUL:  return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Build an arbitrary 32-bit value from single digits by Horner's rule in
    // base 9: d0, then "9 * d +" for each further digit. Wrapping arithmetic
    // makes this reach every bit pattern, the most negative value included.
    task automatic append_number(input logic [31:0] v);
        logic [7:0] digits [$];
        int unsigned i;
        do begin
            digits.push_front(CH_ZERO + 8'(v % 9));
            v = v / 9;
        end while (v != 0);
        line_buf.push_back(digits[0]);
        for (i = 1; i < digits.size(); i++) begin
            line_buf.push_back(CH_NINE);
            line_buf.push_back(CH_STAR);
            line_buf.push_back(digits[i]);
            line_buf.push_back(CH_PLUS);
        end
    endtask

    // A well-formed expression over the given number of digit operands, with
    // random operators and stray spaces (a trailing space may end up last).
    task automatic append_wellformed(input int unsigned operands);
        int unsigned left;
        int unsigned depth;
        left  = operands;
        depth = 0;
        while (left != 0 || depth > 1) begin
            if (depth < 2 || (left != 0 && $urandom_range(0, 1) == 1)) begin
                line_buf.push_back(random_digit());
                left--;
                depth++;
            end else begin
                line_buf.push_back(random_operator());
                depth--;
            end
            if ($urandom_range(0, 5) == 0)
                line_buf.push_back(CH_SPACE);
        end
    endtask

    // Deep stack: push past the top to provoke dropped pushes.
    task automatic append_deep(input int unsigned pushes);
        repeat (pushes) line_buf.push_back(random_digit());
        repeat ($urandom_range(0, 4)) line_buf.push_back(random_operator());
    endtask

    // Send the built line, one transfer per char, flagging the last one.
    // Valid is not dropped between chars unless a gap is inserted.
    task automatic send_line();
        int unsigned idx;
        for (idx = 0; idx < line_buf.size(); idx++) begin
            if (tx_gaps && $urandom_range(0, 3) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_valid    <= 1'b1;
            char_code   <= line_buf[idx];
            end_of_expr <= (idx == line_buf.size() - 1);
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            sent++;
        end
        line_buf.delete();
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned cut;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        char_code   <= '0;
        end_of_expr <= 1'b0;
        rx_stalls   <= 1'b0;
        tx_gaps     = 1'b0;
        sent        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on the input side.
        // Lowest code is junk, 9 5 - leaves 4, and a space closes the expression.
        line_buf = '{CH_LOWEST, CH_NINE, CH_ZERO + 8'd5, CH_MINUS, CH_SPACE};
        send_line();
        // Operator on an empty stack: both pops underflow, -1 + -1.
        line_buf = '{CH_PLUS};
        send_line();
        // Lone space: final pop of an empty stack.
        line_buf = '{CH_SPACE};
        send_line();
        // Zero divisor forces 0 and flags it; the flag sticks past the multiply.
        line_buf = '{CH_ZERO + 8'd7, CH_ZERO, CH_SLASH, CH_ZERO + 8'd3, CH_STAR};
        send_line();
        // 6 3 * 2 / 8 - gives 1, then the highest code ends the expression.
        line_buf = '{CH_ZERO + 8'd6, CH_ZERO + 8'd3, CH_STAR, CH_ZERO + 8'd2, CH_SLASH,
                     CH_ZERO + 8'd8, CH_MINUS, CH_HIGHEST};
        send_line();
        // -7 / 2 truncates toward zero to -3.
        line_buf = '{CH_ZERO, CH_ZERO + 8'd7, CH_MINUS, CH_ZERO + 8'd2, CH_SLASH};
        send_line();
        // Plain add, last flag on the operator.
        line_buf = '{CH_NINE, CH_ZERO + 8'd4, CH_PLUS};
        send_line();

        // Random part opens with a guaranteed overflow and most-negative / -1,
        // then mixes well-formed, broken, junk, wide-value and deep expressions.
        tx_gaps = 1'b1;
        rx_stalls <= 1'b1;
        append_deep(66);
        send_line();
        append_number(32'h8000_0000);
        line_buf.push_back(CH_ZERO);
        line_buf.push_back(CH_ZERO + 8'd1);
        line_buf.push_back(CH_MINUS);
        line_buf.push_back(CH_SLASH);
        send_line();

        while (sent < ITEM_TARGET) begin
            // Idle in phases so some stretches run back to back; none at the tail.
            tx_gaps = (sent < QUIET_AFTER) && ($urandom_range(0, 2) != 0);
            rx_stalls <= (sent < QUIET_AFTER) && ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                append_wellformed($urandom_range(1, 8));
            end else if (pick < 78) begin
                // Broken: inject junk, add a surplus operator or chop the tail.
                append_wellformed($urandom_range(1, 6));
                case ($urandom_range(0, 2))
                    0: line_buf.insert($urandom_range(0, line_buf.size()), 8'($urandom));
                    1: line_buf.push_back(random_operator());
                    default:
                    begin
                        cut = $urandom_range(1, line_buf.size());
                        while (line_buf.size() > cut) void'(line_buf.pop_back());
                    end
                endcase
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom));
            end else if (pick < 98) begin
                // Wide operands: mostly a small divisor so divides stay nontrivial.
                append_number($urandom);
                if ($urandom_range(0, 2) == 0)
                    append_number($urandom);
                else
                    append_number($urandom_range(0, 20));
                line_buf.push_back(random_operator());
            end else begin
                append_deep($urandom_range(60, 68));
            end
            send_line();
        end
        in_valid    <= 1'b0;
        end_of_expr <= 1'b0;
        rx_stalls   <= 1'b0;

        // Drain: wait for every predicted result, then give the block time to
        // show any stray output. A result still owed at the end fails the run.
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
